@@ design/acm_pkg.sv @@
// Shared types, constants and codes of the audio capture level meter.
package acm_pkg;

    // Field widths.
    localparam int LEN_W  = 21;
    localparam int SMP_W  = 16;
    localparam int LVL_W  = 16;
    localparam int SUM_W  = 51;
    localparam int ERR_W  = 4;
    localparam int NUM_W  = 16;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int PROD_W = 31;

    // Configuration port.
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 21;

    // Register reset values.
    localparam logic [LEN_W-1:0] LEN_RESET  = 21'd64000;
    localparam logic [LVL_W-1:0] CLIP_RESET = 16'd32760;
    localparam logic [ERR_W-1:0] ERR_RESET  = 4'd5;
    localparam logic [ERR_W-1:0] ERR_MAX    = 4'd15;

    // Divide and square root sequencing.
    localparam int WORK_W     = 52;
    localparam int ROOT_W     = 26;
    localparam int REM_W      = 27;
    localparam int CSU_W      = 29;
    localparam int DIV_STEPS  = 51;
    localparam int ROOT_STEPS = 26;
    localparam int STEP_W     = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_ERROR  = 2'd2,
        CMD_STOP   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        MODE_IDLE      = 2'd0,
        MODE_RECORDING = 2'd1,
        MODE_COMPLETE  = 2'd2,
        MODE_FAILED    = 2'd3
    } mode_t;

    typedef enum logic [CFG_AW-1:0] {
        REG_CAPTURE_LENGTH = 2'd0,
        REG_CLIP_THRESHOLD = 2'd1,
        REG_MAX_ERROR_RUN  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_FIN,
        ST_OUT
    } ctl_state_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_ROOT,
        F_DONE
    } fin_state_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } fin_req_t;

    typedef struct packed {
        logic             done;
        logic [LVL_W-1:0] rms;
    } fin_rsp_t;

endpackage

@@ design/acm_in_if.sv @@
// Request channel carrying commands and samples into the level meter.
interface acm_in_if;
    import acm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [SMP_W-1:0] sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink (input valid, input cmd, input sample, output ready);
endinterface

@@ design/acm_out_if.sv @@
// Result channel carrying the meter status after each request.
interface acm_out_if;
    import acm_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  samples_taken;
    logic [LVL_W-1:0]  peak_level;
    logic [LEN_W-1:0]  clip_total;
    logic [LVL_W-1:0]  rms_level;
    logic [NUM_W-1:0]  capture_number;

    modport source (output valid, output status, output samples_taken, output peak_level,
                    output clip_total, output rms_level, output capture_number,
                    input ready);
    modport sink (input valid, input status, input samples_taken, input peak_level,
                  input clip_total, input rms_level, input capture_number,
                  output ready);
endinterface

@@ design/acm_csu.sv @@
// Shared compare and subtract unit used by both the divider and the square root.
module acm_csu (
    input  logic [acm_pkg::CSU_W-1:0] a,
    input  logic [acm_pkg::CSU_W-1:0] b,
    output logic                      ge,
    output logic [acm_pkg::CSU_W-1:0] diff
);
    import acm_pkg::*;

    logic [CSU_W:0] sub;

    assign sub  = {1'b0, a} - {1'b0, b};
    assign ge   = ~sub[CSU_W];
    assign diff = sub[CSU_W-1:0];
endmodule

@@ design/acm_finish.sv @@
// Sequencer that computes floor(sqrt(floor(sum / n))) one bit per cycle on one shared unit.
module acm_finish (
    input  logic              clk,
    input  logic              rst_n,
    input  acm_pkg::fin_req_t req,
    output acm_pkg::fin_rsp_t rsp
);
    import acm_pkg::*;

    fin_state_t        state_reg, state_next;
    logic [WORK_W-1:0] work_reg, work_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [LEN_W-1:0]  div_reg, div_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [CSU_W-1:0]  csu_a;
    logic [CSU_W-1:0]  csu_b;
    logic [CSU_W-1:0]  csu_diff;
    logic              csu_ge;

    acm_csu u_csu (
        .a    (csu_a),
        .b    (csu_b),
        .ge   (csu_ge),
        .diff (csu_diff)
    );

    always_comb
    begin
        state_next = state_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        div_next   = div_reg;
        step_next  = step_reg;
        csu_a      = '0;
        csu_b      = '0;
        case (state_reg)
            F_IDLE:
            begin
                if (req.start)
                begin
                    work_next = {1'b0, req.dividend};
                    div_next  = req.divisor;
                    rem_next  = '0;
                    root_next = '0;
                    step_next = '0;
                    // An empty capture has an RMS of zero and skips the arithmetic.
                    state_next = (req.divisor == '0) ? F_DONE : F_DIV;
                end
            end
            F_DIV:
            begin
                // Restoring division: one quotient bit per cycle, shifted into the work word.
                csu_a    = CSU_W'({rem_reg[LEN_W-1:0], work_reg[SUM_W-1]});
                csu_b    = CSU_W'(div_reg);
                rem_next = REM_W'(csu_ge ? csu_diff[LEN_W-1:0] : csu_a[LEN_W-1:0]);
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    // The quotient becomes the radicand with a clear top bit.
                    work_next  = {1'b0, work_reg[SUM_W-2:0], csu_ge};
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = F_ROOT;
                end
                else
                begin
                    work_next = {work_reg[WORK_W-2:0], csu_ge};
                end
            end
            F_ROOT:
            begin
                // Digit-by-digit square root: two radicand bits in, one root bit out.
                csu_a     = {rem_reg, work_reg[WORK_W-1 -: 2]};
                csu_b     = {1'b0, root_reg, 2'b01};
                rem_next  = csu_ge ? csu_diff[REM_W-1:0] : csu_a[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], csu_ge};
                work_next = {work_reg[WORK_W-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    state_next = F_DONE;
                end
            end
            F_DONE:
            begin
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        div_reg  <= div_next;
    end

    assign rsp.done = (state_reg == F_DONE);
    assign rsp.rms  = root_reg[LVL_W-1:0];
endmodule

@@ design/audio_capture_level_meter_unit.sv @@
// Top level of the audio capture level meter: control sequencer, statistics and channels.
// A recorded sample passes through the accumulate state before the output state; any other
// request goes straight there. A completing sample or stop first runs 51 divide and 26 root
// steps on the one compare-subtract unit, unless no samples were taken, then hands back the root.
// The input is ready only when idle, so a new request waits until the last result is loaded.
// Reset clears the statistics, capture counter and mode, and loads the register defaults.
module audio_capture_level_meter_unit #(
    parameter int MAX_SAMPLES = 1048576
) (
    input  logic                       clk,
    input  logic                       rst_n,
    acm_in_if.sink                     in_ch,
    acm_out_if.source                  out_ch,
    input  logic                       cfg_we,
    input  logic [acm_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [acm_pkg::CFG_DW-1:0] cfg_wdata
);
    import acm_pkg::*;

    localparam int TGT_W = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W = (TGT_W > LEN_W) ? TGT_W : LEN_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_SAMPLES);

    // Configuration registers.
    logic [LEN_W-1:0] len_reg;
    logic [LVL_W-1:0] clip_thr_reg;
    logic [ERR_W-1:0] max_err_reg;

    // Capture statistics.
    ctl_state_t        state_reg, state_next;
    mode_t             mode_reg;
    logic [LEN_W-1:0]  count_reg;
    logic [LVL_W-1:0]  peak_reg;
    logic [LEN_W-1:0]  clip_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [ERR_W-1:0]  err_reg;
    logic [NUM_W-1:0]  done_cnt_reg;
    logic [LVL_W-1:0]  rms_reg;
    logic [PROD_W-1:0] prod_reg;

    // Result register.
    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [LEN_W-1:0]  out_count_reg;
    logic [LVL_W-1:0]  out_peak_reg;
    logic [LEN_W-1:0]  out_clip_reg;
    logic [LVL_W-1:0]  out_rms_reg;
    logic [NUM_W-1:0]  out_num_reg;

    logic              accept;
    logic              recording;
    logic              out_load;
    cmd_t              cmd;
    logic [SMP_W-1:0]  sample_u;
    logic [LVL_W-1:0]  mag;
    logic [ERR_W-1:0]  err_inc;
    logic [CMP_W-1:0]  len_ext;
    logic [CMP_W-1:0]  target;
    logic              tgt_hit;
    logic [2*LVL_W-1:0] square;

    fin_req_t          fin_req;
    fin_rsp_t          fin_rsp;

    acm_finish u_finish (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fin_req),
        .rsp   (fin_rsp)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign cmd         = cmd_t'(in_ch.cmd);
    assign recording   = (mode_reg == MODE_RECORDING);
    assign out_load    = (state_reg == ST_OUT) && (!out_valid_reg || out_ch.ready);

    // The most negative sample wraps to 0x8000, which reads as a magnitude of 32768.
    assign sample_u = in_ch.sample;
    assign mag      = sample_u[SMP_W-1] ? (~sample_u + 16'd1) : sample_u;
    assign square   = mag * mag;
    assign err_inc  = (err_reg != ERR_MAX) ? (err_reg + 4'd1) : err_reg;
    assign sum_next = sum_reg + SUM_W'(prod_reg);

    assign len_ext = CMP_W'(len_reg);
    assign target  = (len_ext > MAX_CMP) ? MAX_CMP : len_ext;
    assign tgt_hit = (CMP_W'(count_reg) >= target);

    always_comb
    begin
        state_next       = state_reg;
        fin_req.start    = 1'b0;
        fin_req.dividend = sum_reg;
        fin_req.divisor  = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_SAMPLE:
                        begin
                            state_next = recording ? ST_ACC : ST_OUT;
                        end
                        CMD_STOP:
                        begin
                            if (recording)
                            begin
                                fin_req.start = 1'b1;
                                state_next    = ST_FIN;
                            end
                            else
                            begin
                                state_next = ST_OUT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_ACC:
            begin
                // The divider latches the sum including this sample's square.
                fin_req.dividend = sum_next;
                if (tgt_hit)
                begin
                    fin_req.start = 1'b1;
                    state_next    = ST_FIN;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_FIN:
            begin
                if (fin_rsp.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= LEN_RESET;
            clip_thr_reg <= CLIP_RESET;
            max_err_reg  <= ERR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                REG_CAPTURE_LENGTH: len_reg      <= cfg_wdata[LEN_W-1:0];
                REG_CLIP_THRESHOLD: clip_thr_reg <= cfg_wdata[LVL_W-1:0];
                REG_MAX_ERROR_RUN:  max_err_reg  <= cfg_wdata[ERR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            count_reg    <= '0;
            peak_reg     <= '0;
            clip_reg     <= '0;
            sum_reg      <= '0;
            err_reg      <= '0;
            done_cnt_reg <= '0;
            rms_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                case (cmd)
                    CMD_START:
                    begin
                        if (!recording)
                        begin
                            count_reg <= '0;
                            peak_reg  <= '0;
                            clip_reg  <= '0;
                            sum_reg   <= '0;
                            err_reg   <= '0;
                            rms_reg   <= '0;
                            // A zero target finishes the capture at once with an RMS of zero.
                            if (target == '0)
                            begin
                                done_cnt_reg <= done_cnt_reg + 16'd1;
                                mode_reg     <= MODE_COMPLETE;
                            end
                            else
                            begin
                                mode_reg <= MODE_RECORDING;
                            end
                        end
                    end
                    CMD_SAMPLE:
                    begin
                        if (recording)
                        begin
                            if (mag > peak_reg)
                            begin
                                peak_reg <= mag;
                            end
                            if (mag >= clip_thr_reg)
                            begin
                                clip_reg <= clip_reg + 21'd1;
                            end
                            count_reg <= count_reg + 21'd1;
                            err_reg   <= '0;
                        end
                    end
                    CMD_ERROR:
                    begin
                        if (recording)
                        begin
                            err_reg <= err_inc;
                            if (err_inc >= max_err_reg)
                            begin
                                mode_reg <= MODE_FAILED;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == ST_ACC)
            begin
                sum_reg <= sum_next;
            end
            if ((state_reg == ST_FIN) && fin_rsp.done)
            begin
                rms_reg      <= fin_rsp.rms;
                done_cnt_reg <= done_cnt_reg + 16'd1;
                mode_reg     <= MODE_COMPLETE;
            end
        end
    end

    // The square is registered here and added to the sum in the following cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg <= square[PROD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= mode_reg;
            out_count_reg  <= count_reg;
            out_peak_reg   <= peak_reg;
            out_clip_reg   <= clip_reg;
            out_rms_reg    <= (mode_reg == MODE_COMPLETE) ? rms_reg : '0;
            out_num_reg    <= done_cnt_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status         = out_status_reg;
    assign out_ch.samples_taken  = out_count_reg;
    assign out_ch.peak_level     = out_peak_reg;
    assign out_ch.clip_total     = out_clip_reg;
    assign out_ch.rms_level      = out_rms_reg;
    assign out_ch.capture_number = out_num_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("control stayed idle after accepting a request");

    a_finish_completes: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && fin_rsp.done) |=> (mode_reg == MODE_COMPLETE))
        else $error("finished root did not mark the capture complete");

    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg <= 16'd32768)
        else $error("peak magnitude above full scale");

    a_rms_only_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_rms_reg != '0)) |-> (out_status_reg == MODE_COMPLETE))
        else $error("nonzero RMS reported outside a complete capture");
endmodule
